>>> rtl/mme_pkg.sv
// Shared types and constants of the Montgomery exponentiation block.
package mme_pkg;

  localparam int LIMB_BITS     = 16;
  localparam int MAX_LIMBS_DEF = 64;
  localparam int IDX_W         = 6;
  localparam int CFG_W         = 7;
  localparam int BIT_W         = $clog2(LIMB_BITS);
  localparam int NEWTON_STEPS  = 12;
  localparam int IN_W          = 24;
  localparam int OUT_W         = 24;

  typedef enum logic [1:0] {
    OP_LD_MOD  = 2'd0,
    OP_LD_BASE = 2'd1,
    OP_LD_EXP  = 2'd2,
    OP_START   = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_INV, ST_INIT, ST_DBL, ST_SUB, ST_CPY, ST_SAVE,
    ST_LDB, ST_LDSQ, ST_LDML, ST_LDFIN, ST_MU, ST_MM, ST_MJ, ST_MX,
    ST_SWAP, ST_EROT, ST_OUT
  } st_t;

  typedef enum logic [1:0] {
    JOB_CONV, JOB_SQ, JOB_ML, JOB_FIN
  } job_t;

  typedef struct packed {
    logic                 shift;
    logic [LIMB_BITS-1:0] tail;
  } ring_ctl_t;

endpackage

>>> rtl/mme_cell.sv
// One limb cell of a rotating limb row.
module mme_cell (
  input  logic                         clk,
  input  logic                         shift,
  input  logic                         act,
  input  logic                         tail,
  input  logic [mme_pkg::LIMB_BITS-1:0] tail_in,
  input  logic [mme_pkg::LIMB_BITS-1:0] nbr_in,
  input  logic                         we,
  input  logic [mme_pkg::LIMB_BITS-1:0] wdata,
  output logic [mme_pkg::LIMB_BITS-1:0] q
);
  import mme_pkg::*;

  logic [LIMB_BITS-1:0] q_r;

  always_ff @(posedge clk) begin
    if (we) begin
      q_r <= wdata;
    end else if (shift && act) begin
      q_r <= tail ? tail_in : nbr_in;
    end
  end

  assign q = q_r;

endmodule

>>> rtl/mme_ring.sv
// Row of limb cells; limb 0 sits at the head, the row rotates over nl cells.
module mme_ring #(
  parameter int N_CELLS = mme_pkg::MAX_LIMBS_DEF,
  parameter int NLW     = mme_pkg::CFG_W
) (
  input  logic                          clk,
  input  mme_pkg::ring_ctl_t            ctl,
  input  logic [NLW-1:0]                nl,
  input  logic                          we,
  input  logic [mme_pkg::IDX_W-1:0]     widx,
  input  logic [mme_pkg::LIMB_BITS-1:0] wdata,
  output logic [mme_pkg::LIMB_BITS-1:0] head
);
  import mme_pkg::*;

  logic [LIMB_BITS-1:0] q [N_CELLS];
  logic [NLW-1:0]       nlm1;

  assign nlm1 = nl - 1'b1;

  for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
    localparam logic [NLW-1:0] KI = NLW'(k);
    logic [LIMB_BITS-1:0] nbr;
    if (k == N_CELLS - 1) begin : g_end
      assign nbr = ctl.tail;
    end else begin : g_mid
      assign nbr = q[k+1];
    end
    mme_cell u_cell (
      .clk     (clk),
      .shift   (ctl.shift),
      .act     (KI < nl),
      .tail    (KI == nlm1),
      .tail_in (ctl.tail),
      .nbr_in  (nbr),
      .we      (we && (32'(widx) == k)),
      .wdata   (wdata),
      .q       (q[k])
    );
  end

  assign head = q[0];

endmodule

>>> rtl/montgomery_modular_exponentiation.sv
// Top level: Montgomery exponentiation over rotating rows of 16-bit limb cells.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tdata: operation, limb_index, limb_value
//  out_    | out | out_tvalid/out_tready| tdata: result_limb, result_index; tlast
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_data: active_limbs
//
// Loads are written straight into the rows. A start with L limbs runs 32*L bit-serial doublings
// for R and R^2, then P = 16*L + 2 .. 32*L + 2 Montgomery products, then gives L result words.
// The products use a single limb multiply-accumulate at the head of the rows
// (one limb pair per cycle).
// An even modulus skips the work and gives L zero words. No clearing pass after reset.
// The output waits on out_tready without losing state; input is taken only when idle.
module montgomery_modular_exponentiation #(
  parameter int MAX_LIMBS = mme_pkg::MAX_LIMBS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [mme_pkg::IN_W-1:0]   in_tdata,   // operation, limb_index, limb_value
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [mme_pkg::OUT_W-1:0]  out_tdata,  // result_limb, result_index, pad
  output logic                       out_tlast,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mme_pkg::CFG_W-1:0]  cfg_data
);
  import mme_pkg::*;

  localparam int NB  = $clog2(MAX_LIMBS + 1);
  localparam int NLW = (NB > CFG_W) ? NB : CFG_W;
  localparam int DW  = NLW + 5;
  localparam int LB  = LIMB_BITS;

  st_t  state_r, state_nxt;
  job_t job_r, job_nxt;

  logic [CFG_W-1:0] active_r;
  logic [NLW-1:0]   cnt_r, cnt_nxt, oc_r, oc_nxt, lcnt_r, lcnt_nxt;
  logic [DW-1:0]    dcnt_r, dcnt_nxt;
  logic [BIT_W-1:0] bcnt_r, bcnt_nxt;
  logic [2*LB+1:LB] c_r, c_nxt;
  logic [1:0]       tl_r, tl_nxt;
  logic             bw_r, bw_nxt, sel_r, sel_nxt, dmode_r, dmode_nxt, zero_r, zero_nxt;
  logic [LB-1:0]    u_r, u_nxt, m_r, m_nxt, x_r, x_nxt, p_r, p_nxt, ninv_r, ninv_nxt;

  logic [LB-1:0] n_hd, bas_hd, e_hd, a_hd, b_hd, t_hd, s_hd, m_hd;
  ring_ctl_t     n_ctl, bas_ctl, e_ctl, a_ctl, b_ctl, t_ctl, s_ctl, m_ctl;

  // input word fields
  op_t            in_op;
  logic [IDX_W-1:0] in_idx;
  logic [LB-1:0]  in_val;
  assign in_op  = op_t'(in_tdata[1:0]);
  assign in_idx = in_tdata[7:2];
  assign in_val = in_tdata[23:8];

  logic in_acc, out_acc;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == ST_OUT);
  assign out_acc    = out_tvalid && out_tready;
  assign cfg_ready  = 1'b1;

  // effective limb count
  logic [NLW-1:0] cfg_ext, nl, nlm1;
  assign cfg_ext = NLW'(active_r);
  assign nl = (active_r == '0) ? NLW'(1) :
              (cfg_ext > NLW'(MAX_LIMBS)) ? NLW'(MAX_LIMBS) : cfg_ext;
  assign nlm1 = nl - 1'b1;

  logic          last_w, ebit, nb_more;
  logic [DW-1:0] dnext, n16, n32;
  assign last_w  = (cnt_r == nlm1);
  assign ebit    = e_hd[bcnt_r];
  assign dnext   = dcnt_r + 1'b1;
  assign n16     = DW'({nl, 4'b0000});
  assign n32     = DW'({nl, 5'b00000});
  assign nb_more = (bcnt_r != '0) || (lcnt_r != '0);

  // datapath arithmetic
  logic [2*LB-1:0] p_ab, p_mn, p_um, p_nx, p_xx;
  logic [LB+1:0]   cin;
  logic [2*LB+1:0] s_mac;
  logic [LB+2:0]   s_top;
  logic [LB:0]     d_sub;
  assign p_ab  = a_hd * b_hd;
  assign p_mn  = m_r * n_hd;
  assign p_um  = u_r * ninv_r;
  assign p_nx  = n_hd * x_r;
  assign p_xx  = x_r * (LB'(2) - p_r);
  // the row carry can reach 17 bits
  assign cin   = (cnt_r == '0) ? '0 : c_r;
  assign s_mac = (2*LB+2)'(t_hd) + (2*LB+2)'(p_ab) + (2*LB+2)'(p_mn) + (2*LB+2)'(cin);
  assign s_top = (LB+3)'(tl_r) + (LB+3)'(c_r);
  assign d_sub = {1'b0, t_hd} - {1'b0, n_hd} - (LB+1)'((cnt_r == '0) ? 1'b0 : bw_r);

  mme_ring #(.N_CELLS(MAX_LIMBS), .NLW(NLW)) u_n (
    .clk(clk), .ctl(n_ctl), .nl(nl), .we(in_acc && in_op == OP_LD_MOD),
    .widx(in_idx), .wdata(in_val), .head(n_hd));
  mme_ring #(.N_CELLS(MAX_LIMBS), .NLW(NLW)) u_bas (
    .clk(clk), .ctl(bas_ctl), .nl(nl), .we(in_acc && in_op == OP_LD_BASE),
    .widx(in_idx), .wdata(in_val), .head(bas_hd));
  mme_ring #(.N_CELLS(MAX_LIMBS), .NLW(NLW)) u_e (
    .clk(clk), .ctl(e_ctl), .nl(nl), .we(in_acc && in_op == OP_LD_EXP),
    .widx(in_idx), .wdata(in_val), .head(e_hd));
  mme_ring #(.N_CELLS(MAX_LIMBS), .NLW(NLW)) u_a (
    .clk(clk), .ctl(a_ctl), .nl(nl), .we(1'b0), .widx('0), .wdata('0), .head(a_hd));
  mme_ring #(.N_CELLS(MAX_LIMBS), .NLW(NLW)) u_b (
    .clk(clk), .ctl(b_ctl), .nl(nl), .we(1'b0), .widx('0), .wdata('0), .head(b_hd));
  mme_ring #(.N_CELLS(MAX_LIMBS), .NLW(NLW)) u_t (
    .clk(clk), .ctl(t_ctl), .nl(nl), .we(1'b0), .widx('0), .wdata('0), .head(t_hd));
  mme_ring #(.N_CELLS(MAX_LIMBS), .NLW(NLW)) u_s (
    .clk(clk), .ctl(s_ctl), .nl(nl), .we(1'b0), .widx('0), .wdata('0), .head(s_hd));
  mme_ring #(.N_CELLS(MAX_LIMBS), .NLW(NLW)) u_m (
    .clk(clk), .ctl(m_ctl), .nl(nl), .we(1'b0), .widx('0), .wdata('0), .head(m_hd));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc && in_op == OP_START) state_nxt = !n_hd[0] ? ST_OUT : ST_INV;
      ST_INV:   if (cnt_r == NLW'(NEWTON_STEPS - 1)) state_nxt = ST_INIT;
      ST_INIT:  if (last_w) state_nxt = ST_DBL;
      ST_DBL:   if (last_w) state_nxt = ST_SUB;
      ST_SUB:   if (last_w) state_nxt = ST_CPY;
      ST_CPY: begin
        if (last_w) begin
          if (dmode_r) begin
            if (dnext == n16)      state_nxt = ST_SAVE;
            else if (dnext == n32) state_nxt = ST_LDB;
            else                   state_nxt = ST_DBL;
          end else begin
            unique case (job_r)
              JOB_CONV: state_nxt = ST_SWAP;
              JOB_FIN:  state_nxt = ST_OUT;
              JOB_SQ, JOB_ML: begin
                if (job_r == JOB_SQ && ebit)   state_nxt = ST_LDML;
                else if (!nb_more)             state_nxt = ST_LDFIN;
                else if (bcnt_r == '0)         state_nxt = ST_EROT;
                else                           state_nxt = ST_LDSQ;
              end
              default: state_nxt = ST_IDLE;
            endcase
          end
        end
      end
      ST_SAVE:  if (last_w) state_nxt = ST_DBL;
      ST_LDB, ST_LDSQ, ST_LDML, ST_LDFIN: if (last_w) state_nxt = ST_MU;
      ST_MU:    state_nxt = ST_MM;
      ST_MM:    state_nxt = ST_MJ;
      ST_MJ:    if (last_w) state_nxt = ST_MX;
      ST_MX:    state_nxt = (oc_r == nlm1) ? ST_SUB : ST_MU;
      ST_SWAP:  if (last_w) state_nxt = (nl == NLW'(1)) ? ST_LDSQ : ST_EROT;
      ST_EROT:  if (cnt_r == nlm1 - 1'b1) state_nxt = ST_LDSQ;
      ST_OUT:   if (out_acc && last_w) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath controls and register updates
  always_comb begin
    job_nxt = job_r;  oc_nxt = oc_r;  lcnt_nxt = lcnt_r;  bcnt_nxt = bcnt_r;
    dcnt_nxt = dcnt_r;  c_nxt = c_r;  tl_nxt = tl_r;  bw_nxt = bw_r;  sel_nxt = sel_r;
    dmode_nxt = dmode_r;  zero_nxt = zero_r;  u_nxt = u_r;  m_nxt = m_r;
    x_nxt = x_r;  p_nxt = p_r;  ninv_nxt = ninv_r;
    n_ctl   = '{shift: 1'b0, tail: n_hd};
    bas_ctl = '{shift: 1'b0, tail: bas_hd};
    e_ctl   = '{shift: 1'b0, tail: e_hd};
    a_ctl   = '{shift: 1'b0, tail: a_hd};
    b_ctl   = '{shift: 1'b0, tail: b_hd};
    t_ctl   = '{shift: 1'b0, tail: t_hd};
    s_ctl   = '{shift: 1'b0, tail: s_hd};
    m_ctl   = '{shift: 1'b0, tail: m_hd};
    if (state_nxt != state_r) begin
      cnt_nxt = '0;
    end else if (state_r == ST_OUT) begin
      cnt_nxt = out_acc ? cnt_r + 1'b1 : cnt_r;
    end else begin
      cnt_nxt = cnt_r + 1'b1;
    end
    unique case (state_r)
      ST_IDLE: begin
        x_nxt    = n_hd;
        zero_nxt = !n_hd[0];
      end
      ST_INV: begin
        // Newton steps for the inverse of the low modulus limb
        if (!cnt_r[0]) p_nxt = p_nx[LB-1:0];
        else           x_nxt = p_xx[LB-1:0];
      end
      ST_INIT: begin
        ninv_nxt  = LB'(0) - x_r;
        dmode_nxt = 1'b1;
        dcnt_nxt  = '0;
        tl_nxt    = '0;
        t_ctl     = '{shift: 1'b1, tail: (cnt_r == '0) ? LB'(1) : '0};
      end
      ST_DBL: begin
        t_ctl = '{shift: 1'b1, tail: {t_hd[LB-2:0], cin[0]}};
        c_nxt = (LB+2)'(t_hd[LB-1]);
        if (last_w) tl_nxt = {1'b0, t_hd[LB-1]};
      end
      ST_SUB: begin
        t_ctl.shift = 1'b1;
        n_ctl.shift = 1'b1;
        s_ctl   = '{shift: 1'b1, tail: d_sub[LB-1:0]};
        bw_nxt  = d_sub[LB];
        sel_nxt = (tl_r != '0) || !d_sub[LB];
      end
      ST_CPY: begin
        s_ctl.shift = 1'b1;
        t_ctl = '{shift: 1'b1, tail: sel_r ? s_hd : t_hd};
        tl_nxt = '0;
        if (last_w) begin
          if (dmode_r) begin
            dcnt_nxt = dnext;
          end else if ((job_r == JOB_SQ && !ebit) || job_r == JOB_ML) begin
            if (bcnt_r != '0) begin
              bcnt_nxt = bcnt_r - 1'b1;
            end else if (lcnt_r != '0) begin
              bcnt_nxt = BIT_W'(LB - 1);
              lcnt_nxt = lcnt_r - 1'b1;
            end
          end
        end
      end
      ST_SAVE: begin
        t_ctl.shift = 1'b1;
        m_ctl = '{shift: 1'b1, tail: t_hd};
      end
      ST_LDB, ST_LDSQ, ST_LDML, ST_LDFIN: begin
        oc_nxt    = '0;
        tl_nxt    = '0;
        dmode_nxt = 1'b0;
        t_ctl = '{shift: 1'b1, tail: '0};
        a_ctl = '{shift: 1'b1, tail: t_hd};
        b_ctl = '{shift: 1'b1, tail: t_hd};
        unique case (state_r)
          ST_LDB: begin
            job_nxt = JOB_CONV;
            bas_ctl.shift = 1'b1;
            a_ctl.tail = bas_hd;
          end
          ST_LDSQ: job_nxt = JOB_SQ;
          ST_LDML: begin
            job_nxt = JOB_ML;
            m_ctl.shift = 1'b1;
            b_ctl.tail = m_hd;
          end
          default: begin
            job_nxt = JOB_FIN;
            b_ctl.tail = (cnt_r == '0) ? LB'(1) : '0;
          end
        endcase
      end
      ST_MU: u_nxt = t_hd + p_ab[LB-1:0];
      ST_MM: m_nxt = p_um[LB-1:0];
      ST_MJ: begin
        // t row shifts down one limb as the sum comes back in at the tail
        a_ctl.shift = 1'b1;
        n_ctl.shift = 1'b1;
        t_ctl = '{shift: 1'b1, tail: s_mac[LB-1:0]};
        c_nxt = s_mac[2*LB+1:LB];
      end
      ST_MX: begin
        t_ctl = '{shift: 1'b1, tail: s_top[LB-1:0]};
        b_ctl.shift = 1'b1;
        tl_nxt = s_top[LB+1:LB];
        oc_nxt = oc_r + 1'b1;
      end
      ST_SWAP: begin
        t_ctl = '{shift: 1'b1, tail: m_hd};
        m_ctl = '{shift: 1'b1, tail: t_hd};
        lcnt_nxt = nlm1;
        bcnt_nxt = BIT_W'(LB - 1);
      end
      ST_EROT: e_ctl.shift = 1'b1;
      ST_OUT:  t_ctl.shift = out_acc;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      active_r <= CFG_W'(MAX_LIMBS_DEF);
      cnt_r    <= '0;
      dmode_r  <= 1'b0;
      zero_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dmode_r <= dmode_nxt;
      zero_r  <= zero_nxt;
      if (cfg_valid && cfg_ready) active_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;   oc_r  <= oc_nxt;   lcnt_r <= lcnt_nxt;  bcnt_r <= bcnt_nxt;
    dcnt_r <= dcnt_nxt;  c_r   <= c_nxt;    tl_r   <= tl_nxt;    bw_r   <= bw_nxt;
    sel_r  <= sel_nxt;   u_r   <= u_nxt;    m_r    <= m_nxt;     x_r    <= x_nxt;
    p_r    <= p_nxt;     ninv_r <= ninv_nxt;
  end

  assign out_tdata = {2'b00, cnt_r[IDX_W-1:0], zero_r ? LB'(0) : t_hd};
  assign out_tlast = last_w;

endmodule

>>> rtl/mme_chk.sv
// Port-level checks of the exponentiation block, bound to the top level.
module mme_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic [mme_pkg::IN_W-1:0]  in_tdata,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [mme_pkg::OUT_W-1:0] out_tdata,
  input logic                      out_tlast
);
  import mme_pkg::*;

  logic in_acc, out_acc;
  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input taken while results pending");

  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tdata[1:0] != OP_START) |=> in_tready) else $error("load stalled");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tdata[1:0] == OP_START) |=> !in_tready) else $error("start ignored");

  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !out_tlast) |=> out_tvalid &&
      out_tdata[21:16] == $past(out_tdata[21:16]) + 6'd1) else $error("index skip");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_tlast) |=> in_tready) else $error("no return to idle");

endmodule

bind montgomery_modular_exponentiation mme_chk u_mme_chk (.*);

>>> verif/montgomery_modular_exponentiation_tb.sv
// Testbench for the Montgomery exponentiation block: random loads and starts, checked limb by limb.
`timescale 1ns / 1ps

module montgomery_modular_exponentiation_tb;
  import mme_pkg::*;

  localparam int WATCHDOG_LIMIT = 600000;
  localparam int SETTLE_CYCLES  = 50;

  typedef struct {
    op_t         op;
    logic [5:0]  idx;
    logic [15:0] val;
  } limb_word_t;

  typedef struct {
    logic [15:0] limb;
    logic [5:0]  idx;
    logic        last;
  } result_word_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;    // operation[1:0], limb_index[7:2], limb_value[23:8]
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;  // result_limb[15:0], result_index[21:16], zero pad
  logic out_tlast;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  montgomery_modular_exponentiation uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  limb_word_t   pending_q[$];
  result_word_t power_q[$];
  logic [15:0]  mod_mem[64];
  logic [15:0]  base_mem[64];
  logic [15:0]  exp_mem[64];
  logic [6:0]   limb_count;
  int           mismatches;
  int           in_gap;
  int           out_gap;
  bit           steady;
  int           idle_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [1023:0] mul_mod(logic [1023:0] a, logic [1023:0] b,
                                            logic [1023:0] n);
    logic [2047:0] p;
    p = {1024'b0, a} * {1024'b0, b};
    p = p % {1024'b0, n};
    return p[1023:0];
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    mismatches++;
  endtask

  // Works out the result limbs of a start from the stored operands.
  task automatic predict_power();
    int nl;
    logic [1023:0] n, b, e, acc;
    result_word_t w;
    nl = limb_count;
    if (nl < 1) nl = 1;
    if (nl > 64) nl = 64;
    n = '0; b = '0; e = '0;
    for (int i = 0; i < nl; i++) begin
      n[i*16 +: 16] = mod_mem[i];
      b[i*16 +: 16] = base_mem[i];
      e[i*16 +: 16] = exp_mem[i];
    end
    if (!mod_mem[0][0]) begin
      acc = '0;  // even modulus: all-zero result
    end else begin
      acc = 1024'd1 % n;
      b = b % n;
      for (int k = nl*16 - 1; k >= 0; k--) begin
        acc = mul_mod(acc, acc, n);
        if (e[k]) acc = mul_mod(acc, b, n);
      end
    end
    for (int i = 0; i < nl; i++) begin
      w.limb = acc[i*16 +: 16];
      w.idx  = i[5:0];
      w.last = (i == nl - 1);
      power_q.push_back(w);
    end
  endtask

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_gap    <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap > 0 && !steady) begin
        in_gap    <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        limb_word_t it;
        it = pending_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {it.val, it.idx, it.op};
        in_gap    <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Accepted words update the shadow stores
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      case (op_t'(in_tdata[1:0]))
        OP_LD_MOD:  mod_mem[in_tdata[7:2]]  = in_tdata[23:8];
        OP_LD_BASE: base_mem[in_tdata[7:2]] = in_tdata[23:8];
        OP_LD_EXP:  exp_mem[in_tdata[7:2]]  = in_tdata[23:8];
        OP_START:   predict_power();
        default: ;
      endcase
    end
  end

  // Receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    <= 0;
    end else if (steady) begin
      out_tready <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap    <= out_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_gap <= pick_gap();
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (power_q.size() == 0) begin
        report("unexpected word", out_tdata[15:0], 0);
      end else begin
        result_word_t w;
        w = power_q.pop_front();
        if (out_tdata[15:0] !== w.limb) report("result_limb", out_tdata[15:0], w.limb);
        if (out_tdata[21:16] !== w.idx) report("result_index", out_tdata[21:16], w.idx);
        if (out_tlast !== w.last) report("last", out_tlast, w.last);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("montgomery_modular_exponentiation_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_word(op_t op, int idx, int val);
    limb_word_t it;
    it.op  = op;
    it.idx = idx[5:0];
    it.val = val[15:0];
    pending_q.push_back(it);
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_tvalid || power_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limb_count(int v);
    wait_drained();
    cfg_data  <= v[6:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    limb_count = v[6:0];
  endtask

  // One well-formed exponentiation with random operands over nl limbs
  task automatic queue_power(int nl);
    int kind;
    kind = $urandom_range(0, 19);
    for (int i = 0; i < nl; i++) begin
      int m;
      m = $urandom_range(0, 65535);
      if (i == 0) m = (kind == 0) ? (m & 16'hfffe) : (m | 1);
      if (kind == 1) m = (i == 0) ? 1 : 0;
      if (i == nl - 1 && kind > 1 && m == 0) m = 16'h8000;
      add_word(OP_LD_MOD, i, m);
    end
    for (int i = 0; i < nl; i++)
      add_word(OP_LD_BASE, i, (kind == 2) ? 16'hffff : $urandom_range(0, 65535));
    for (int i = 0; i < nl; i++)
      add_word(OP_LD_EXP, i, (kind == 3) ? 0 : $urandom_range(0, 65535));
    // limbs beyond the active count must not matter
    if ($urandom_range(0, 3) == 0 && nl < 64)
      add_word(op_t'($urandom_range(0, 2)), $urandom_range(nl, 63), $urandom_range(0, 65535));
    add_word(OP_START, $urandom_range(0, 63), $urandom_range(0, 65535));
  endtask

  initial begin
    int nl;
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    steady     = 1'b0;
    mismatches = 0;
    limb_count = 7'd64;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the low limbs; wider odd-modulus runs load all of their own limbs
    write_limb_count(1);
    for (int i = 0; i < 8; i++) begin
      add_word(OP_LD_MOD, i, (i == 0) ? ($urandom_range(0, 65535) | 1) : $urandom_range(0, 65535));
      add_word(OP_LD_BASE, i, $urandom_range(0, 65535));
      add_word(OP_LD_EXP, i, $urandom_range(0, 65535));
    end

    // single limb corner cases
    add_word(OP_LD_MOD, 0, 16'hffff);
    add_word(OP_LD_BASE, 0, 16'hffff);
    add_word(OP_LD_EXP, 0, 16'hffff);
    add_word(OP_START, 0, 0);
    add_word(OP_LD_EXP, 0, 0);                // zero exponent
    add_word(OP_START, 63, 16'hffff);
    add_word(OP_LD_MOD, 0, 1);                // modulus one
    add_word(OP_LD_EXP, 0, 16'h8001);
    add_word(OP_START, 0, 0);
    add_word(OP_LD_MOD, 0, 16'hfffe);         // even modulus
    add_word(OP_START, 0, 0);
    add_word(OP_LD_MOD, 0, 3);                // base above modulus
    add_word(OP_LD_EXP, 0, 5);
    add_word(OP_START, 0, 0);
    add_word(OP_LD_MOD, 63, 16'h1234);        // above the active count
    add_word(OP_START, 0, 0);

    write_limb_count(0);                      // acts as one limb
    add_word(OP_LD_MOD, 0, 16'h8001);
    add_word(OP_START, 0, 0);

    // full width only with an even modulus, where the block skips the work
    write_limb_count(64);
    add_word(OP_LD_MOD, 0, 16'h0002);
    add_word(OP_START, 0, 0);
    write_limb_count(127);
    add_word(OP_START, 0, 0);

    write_limb_count(8);
    steady = 1'b1;
    queue_power(8);
    wait_drained();
    steady = 1'b0;

    // random part, mostly small limb counts
    for (int grp = 0; grp < 3; grp++) begin
      nl = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
      write_limb_count(nl);
      queue_power(nl);
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("montgomery_modular_exponentiation_tb: PASS");
    end else begin
      $display("montgomery_modular_exponentiation_tb: FAIL");
    end
    $finish;
  end

endmodule
